// ----- design/hedc_pkg.sv -----
// ----------------------------------------------------------------------------
// hedc_pkg
// Shared types, register codes and the CRC-16/CCITT-FALSE byte step for the
// host envelope deframer.
// ----------------------------------------------------------------------------
package hedc_pkg;

	// Configuration register codes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENV_VERSION  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MARKER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_VER    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_KIND   = 3'd4;

	// Register values after reset.
	localparam logic [7:0] START_BYTE_RST   = 8'hA5;
	localparam logic [7:0] ENV_VERSION_RST  = 8'h01;
	localparam logic [7:0] FRAME_MARKER_RST = 8'hD7;
	localparam logic [7:0] FRAME_VER_RST    = 8'h02;
	localparam logic [7:0] FRAME_KIND_RST   = 8'h01;

	// Envelope layout.
	localparam int ENV_VER_POS  = 1;
	localparam int EMIT_FIRST   = 2;
	localparam int INNER_OFFSET = 4;

	// CRC-16/CCITT-FALSE.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_CHECK   = 8'b0000_0010,
		ST_FLUSH   = 8'b0000_0100,
		ST_DECIDE  = 8'b0000_1000,
		ST_SCAN    = 8'b0001_0000,
		ST_COPY    = 8'b0010_0000,
		ST_EMIT_RD = 8'b0100_0000,
		ST_EMIT_WR = 8'b1000_0000
	} hedc_state_t;

	// One beat of envelope data presented to the frame checker, with its role.
	typedef struct packed {
		logic       clr;
		logic       vld;
		logic [7:0] data;
		logic       env_ver;
		logic       marker;
		logic       fver;
		logic       kind;
		logic       crc_en;
		logic       got_hi;
		logic       got_lo;
	} hedc_chk_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- design/hedc_ram.sv -----
// ----------------------------------------------------------------------------
// hedc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module hedc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/hedc_check.sv -----
// ----------------------------------------------------------------------------
// hedc_check
// Frame checker: compares the header bytes against the configured values and
// runs the CRC over the inner frame ahead of its two CRC bytes, one byte per beat.
// ----------------------------------------------------------------------------
module hedc_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          env_version,
	input  logic [7:0]          frame_marker,
	input  logic [7:0]          frame_version,
	input  logic [7:0]          frame_kind,
	input  hedc_pkg::hedc_chk_t beat,
	output logic                pass
);

	import hedc_pkg::*;

	logic        ok_q;
	logic [15:0] crc_q;
	logic [15:0] got_q;
	logic        bad;

	// A header byte that disagrees with its register spoils the envelope.
	assign bad = (beat.env_ver && (beat.data != env_version)) ||
		(beat.marker && (beat.data != frame_marker)) ||
		(beat.fver && (beat.data != frame_version)) ||
		(beat.kind && (beat.data != frame_kind));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else if (beat.clr) begin
			ok_q <= 1'b1;
		end else if (beat.vld && bad) begin
			ok_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat.clr) begin
			crc_q <= CRC_INIT;
		end else if (beat.vld) begin
			if (beat.crc_en) begin
				crc_q <= crc16_byte(crc_q, beat.data);
			end
			if (beat.got_hi) begin
				got_q[15:8] <= beat.data;
			end
			if (beat.got_lo) begin
				got_q[7:0] <= beat.data;
			end
		end
	end

	assign pass = ok_q && (got_q == crc_q);

endmodule

// ----- design/host_envelope_deframer_crc16_core.sv -----
// ----------------------------------------------------------------------------
// host_envelope_deframer_crc16_core
// Host envelope deframer with CRC-16/CCITT-FALSE check of the inner frame.
// ----------------------------------------------------------------------------
// Host bytes are taken one beat per cycle while the block is collecting; with
// an empty buffer every byte other than the start byte is dropped. The
// envelope lives in a single synchronous RAM of ENVELOPE_BYTES entries, and
// every frame-end action walks that RAM through its one registered read
// port. When the byte that fills the buffer arrives, the block stops taking
// input (rx_stall high) and runs the header and CRC check. An accepted
// envelope then emits INNER_FRAME_BYTES + 2 beats, each a RAM read and then
// a load of the output register, which out_stall can hold off. A rejected
// envelope is scanned from its second byte for the next start byte, and the
// bytes from that start byte on are copied down to the head. Input is taken
// again once this is done, even while the last result beat still waits in
// the output register. Configuration writes are expected only while the
// block is idle.
// ----------------------------------------------------------------------------
module host_envelope_deframer_crc16_core #(
	parameter int ENVELOPE_BYTES    = 40,
	parameter int INNER_FRAME_BYTES = 36
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic [hedc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]                     cfg_data,
	// Host byte channel.
	input  logic                           rx_valid,
	output logic                           rx_stall,
	input  logic [7:0]                     rx_byte,
	// Radio frame channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_byte,
	output logic                           out_last
);

	import hedc_pkg::*;

	localparam int AW  = $clog2(ENVELOPE_BYTES);
	localparam int FCW = $clog2(ENVELOPE_BYTES + 1);
	localparam int XW  = $clog2(ENVELOPE_BYTES + INNER_FRAME_BYTES + INNER_OFFSET);

	localparam logic [FCW-1:0] FILL_LAST   = FCW'(ENVELOPE_BYTES - 1);
	localparam logic [XW-1:0]  ENV_X       = XW'(ENVELOPE_BYTES);
	localparam logic [XW-1:0]  ENV_LAST_X  = XW'(ENVELOPE_BYTES - 1);
	localparam logic [XW-1:0]  INN_X       = XW'(INNER_FRAME_BYTES);
	localparam logic [XW-1:0]  INN_M1_X    = XW'(INNER_FRAME_BYTES - 1);
	localparam logic [XW-1:0]  EMIT_LAST_X = XW'(INNER_FRAME_BYTES + 1);
	localparam logic [XW-1:0]  ONE_X       = XW'(1);

	// Configuration registers.
	logic [7:0] start_q;
	logic [7:0] env_ver_q;
	logic [7:0] marker_q;
	logic [7:0] fver_q;
	logic [7:0] kind_q;

	// Sequencer state. cnt_q is the walk index of whichever pass is running;
	// the _s1 registers describe the read whose data the RAM shows now.
	hedc_state_t    state_q;
	logic [FCW-1:0] fill_q;
	logic [XW-1:0]  cnt_q;
	logic [XW-1:0]  hit_q;
	logic [XW-1:0]  idx_s1;
	logic           chk_vld_s1;
	logic           scan_vld_s1;
	logic           copy_vld_s1;
	logic           zero_s1;

	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           out_last_q;

	// RAM ports.
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [7:0]     ram_wdata;
	logic           ram_re;
	logic [XW-1:0]  rd_x;
	logic [7:0]     ram_rdata;

	logic           in_acc;
	logic           keep;
	logic           out_free;
	logic           out_load;
	logic [XW-1:0]  rest_x;
	logic           pass;
	hedc_chk_t      chk;

	assign in_acc   = rx_valid && (state_q == ST_IDLE);
	assign keep     = (fill_q != '0) || (rx_byte == start_q);
	assign rx_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_EMIT_WR) && out_free;
	// Number of bytes that survive a resync from the hit position on.
	assign rest_x   = ENV_X - hit_q;

	// RAM address and enable selection. Entries past the envelope end are
	// never read; zero_s1 makes them read as zero instead.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		rd_x      = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && keep) begin
					ram_we    = 1'b1;
					ram_waddr = fill_q[AW-1:0];
					ram_wdata = rx_byte;
				end
			end
			ST_CHECK: begin
				// Index zero fetches the envelope version byte; index j
				// afterwards fetches inner frame byte j - 1.
				if (cnt_q == '0) begin
					rd_x = XW'(ENV_VER_POS);
				end else begin
					rd_x = cnt_q + XW'(INNER_OFFSET - 1);
				end
				ram_re = (rd_x < ENV_X);
			end
			ST_SCAN: begin
				rd_x   = cnt_q;
				ram_re = (cnt_q < ENV_X);
			end
			ST_COPY: begin
				// Reads run one entry ahead of the write-back, always at a
				// higher address, so no entry is overwritten before it is read.
				rd_x      = hit_q + cnt_q;
				ram_re    = (cnt_q < rest_x);
				ram_we    = copy_vld_s1;
				ram_waddr = idx_s1[AW-1:0];
				ram_wdata = ram_rdata;
			end
			ST_EMIT_RD: begin
				rd_x   = cnt_q + XW'(EMIT_FIRST);
				ram_re = (rd_x < ENV_X);
			end
			default: begin
			end
		endcase
	end

	hedc_ram #(
		.WIDTH(8),
		.DEPTH(ENVELOPE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_x[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Check beats: role of each byte follows from its walk index.
	always_comb begin
		chk.clr     = in_acc && keep && (fill_q == FILL_LAST);
		chk.vld     = chk_vld_s1;
		chk.data    = zero_s1 ? 8'h00 : ram_rdata;
		chk.env_ver = (idx_s1 == '0);
		chk.marker  = (idx_s1 == XW'(1));
		chk.fver    = (idx_s1 == XW'(2));
		chk.kind    = (idx_s1 == XW'(3));
		chk.crc_en  = (idx_s1 != '0) && (idx_s1 < INN_M1_X);
		chk.got_hi  = (idx_s1 == INN_M1_X);
		chk.got_lo  = (idx_s1 == INN_X);
	end

	hedc_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.env_version  (env_ver_q),
		.frame_marker (marker_q),
		.frame_version(fver_q),
		.frame_kind   (kind_q),
		.beat         (chk),
		.pass         (pass)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= START_BYTE_RST;
			env_ver_q   <= ENV_VERSION_RST;
			marker_q    <= FRAME_MARKER_RST;
			fver_q      <= FRAME_VER_RST;
			kind_q      <= FRAME_KIND_RST;
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			hit_q       <= '0;
			idx_s1      <= '0;
			chk_vld_s1  <= 1'b0;
			scan_vld_s1 <= 1'b0;
			copy_vld_s1 <= 1'b0;
			zero_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_START_BYTE:   start_q   <= cfg_data;
					CFG_ENV_VERSION:  env_ver_q <= cfg_data;
					CFG_FRAME_MARKER: marker_q  <= cfg_data;
					CFG_FRAME_VER:    fver_q    <= cfg_data;
					CFG_FRAME_KIND:   kind_q    <= cfg_data;
					default: begin
					end
				endcase
			end

			chk_vld_s1  <= 1'b0;
			scan_vld_s1 <= 1'b0;
			copy_vld_s1 <= 1'b0;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && keep) begin
						fill_q <= fill_q + FCW'(1);
						if (fill_q == FILL_LAST) begin
							cnt_q   <= '0;
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					chk_vld_s1 <= 1'b1;
					idx_s1     <= cnt_q;
					zero_s1    <= !ram_re;
					cnt_q      <= cnt_q + ONE_X;
					if (cnt_q == INN_X) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					// The last check beat is absorbed at the end of this cycle.
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (pass) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						cnt_q   <= ONE_X;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_vld_s1 && (ram_rdata == start_q)) begin
						hit_q   <= idx_s1;
						cnt_q   <= '0;
						state_q <= ST_COPY;
					end else if (scan_vld_s1 && (idx_s1 == ENV_LAST_X)) begin
						fill_q  <= '0;
						state_q <= ST_IDLE;
					end else if (ram_re) begin
						scan_vld_s1 <= 1'b1;
						idx_s1      <= cnt_q;
						cnt_q       <= cnt_q + ONE_X;
					end
				end
				ST_COPY: begin
					if (ram_re) begin
						copy_vld_s1 <= 1'b1;
						idx_s1      <= cnt_q;
						cnt_q       <= cnt_q + ONE_X;
					end
					if (copy_vld_s1 && (idx_s1 == (rest_x - ONE_X))) begin
						fill_q  <= rest_x[FCW-1:0];
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					zero_s1 <= !ram_re;
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						if (cnt_q == EMIT_LAST_X) begin
							fill_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q   <= cnt_q + ONE_X;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload register; it only loads when the slot is free.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= zero_s1 ? 8'h00 : ram_rdata;
			out_last_q <= (cnt_q == EMIT_LAST_X);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	// The buffer is never full while bytes are being collected.
	a_fill_below_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (fill_q < FCW'(ENVELOPE_BYTES)))
		else $error("fill count reached the envelope size while collecting");

	// A write and a read of the RAM in one cycle never hit the same entry.
	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != rd_x[AW-1:0]))
		else $error("RAM read and write collide on one entry");

	// Check beats only come from the check walk.
	a_check_beats: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> ((state_q == ST_CHECK) || (state_q == ST_FLUSH)))
		else $error("check beat outside the check walk");

	// A result beat that is stalled stays in the output slot.
	a_emit_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("output beat dropped while stalled");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the host envelope deframer. Host bytes are
// streamed in envelopes, some well formed, some damaged, some cut short, and
// some as bare noise. Every byte taken by the block also goes through a
// local model of the deframer, which queues the radio frame beats that must
// come out. Both channels stall and idle at random. Register settings change
// between phases, and the extremes are among them.
// ----------------------------------------------------------------------------
module testbench;
	import hedc_pkg::*;

	localparam int ENV_N            = 40;
	localparam int INNER_N          = 36;
	localparam int SETTLE_CYCLES    = 150;
	localparam int HOLDOFF_CYCLES   = 300;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int IDLE_PERCENT     = 27;
	localparam int PHASE_MIN_BYTES  = 10;
	localparam int RANDOM_PHASES    = 2;
	// Indexes past the last register. The block must ignore writes to them.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

	// Ways to damage an envelope before it is sent.
	typedef enum int {
		FLAW_NONE,
		FLAW_ENV_VER,
		FLAW_MARKER,
		FLAW_FVER,
		FLAW_KIND,
		FLAW_CRC_HI,
		FLAW_CRC_LO
	} flaw_t;

	// Content of the free bytes of an envelope.
	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} radio_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [7:0]           cfg_data = 8'h00;
	logic                 rx_valid = 1'b0;
	logic                 rx_stall;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           out_byte;
	logic                 out_last;

	// Bytes waiting to be offered to the block, and the held-back rest of an
	// envelope that is sent in two parts.
	logic [7:0]  host_bytes_todo[$];
	logic [7:0]  tail_bytes[$];
	// Radio frame beats the block still owes.
	radio_beat_t frame_beats_due[$];

	// The bench's copy of the registers, updated as they are written.
	logic [7:0] cfg_start     = START_BYTE_RST;
	logic [7:0] cfg_env_ver   = ENV_VERSION_RST;
	logic [7:0] cfg_marker    = FRAME_MARKER_RST;
	logic [7:0] cfg_fver      = FRAME_VER_RST;
	logic [7:0] cfg_kind      = FRAME_KIND_RST;

	// Model state: the envelope buffer and how many bytes it holds.
	logic [7:0] env_copy[ENV_N];
	int         held = 0;

	// Traffic shaping, set by the sequence and read by both sides.
	bit calm          = 1'b0;
	bit holdoff_armed = 1'b0;
	bit holdoff_done  = 1'b0;
	int holdoff_left  = 0;

	int mismatches          = 0;
	int rx_bytes_taken      = 0;
	int radio_beats_checked = 0;
	int envelopes_passed    = 0;
	int envelopes_dropped   = 0;
	int quiet_cycles        = 0;

	host_envelope_deframer_crc16_core #(
		.ENVELOPE_BYTES   (ENV_N),
		.INNER_FRAME_BYTES(INNER_N)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// One byte step of CRC-16/CCITT-FALSE, MSB first, no reflection.
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	// Envelope bytes past the end of the buffer read as zero. With the
	// default sizes the inner frame never reaches that far, but the model
	// keeps the rule so it stays right for other sizes.
	function automatic logic [7:0] held_at(input int idx);
		return (idx < ENV_N) ? env_copy[idx] : 8'h00;
	endfunction

	// Model of the deframer for one accepted host byte. A full buffer is
	// checked against the registers as they stand right now, not as they
	// stood when the bytes arrived.
	task automatic take_host_byte(input logic [7:0] b);
		logic [15:0] crc;
		logic        good;
		int          skip;
		radio_beat_t beat;
		if (held == 0 && b != cfg_start) return;
		if (held >= ENV_N) held = 0;
		env_copy[held] = b;
		held++;
		if (held != ENV_N) return;

		crc = CRC_INIT;
		for (int i = 0; i < INNER_N - 2; i++) crc = crc_step(crc, held_at(INNER_OFFSET + i));
		good = held_at(ENV_VER_POS) == cfg_env_ver &&
			held_at(INNER_OFFSET) == cfg_marker &&
			held_at(INNER_OFFSET + 1) == cfg_fver &&
			held_at(INNER_OFFSET + 2) == cfg_kind &&
			{held_at(INNER_OFFSET + INNER_N - 2), held_at(INNER_OFFSET + INNER_N - 1)} == crc;

		if (good) begin
			// Two envelope header bytes, then the whole inner frame.
			for (int i = 0; i < INNER_N + 2; i++) begin
				beat.data = (i < 2) ? held_at(EMIT_FIRST + i) : held_at(INNER_OFFSET + i - 2);
				beat.last = (i == INNER_N + 1);
				frame_beats_due.push_back(beat);
			end
			held = 0;
			envelopes_passed++;
		end else begin
			// Resync: keep everything from the next start byte after the head.
			// Those bytes are not looked at again until the buffer is full.
			skip = 0;
			for (int i = 1; i < held && skip == 0; i++) begin
				if (env_copy[i] == cfg_start) skip = i;
			end
			if (skip != 0) begin
				for (int j = 0; j < held - skip; j++) env_copy[j] = env_copy[j + skip];
				held = held - skip;
			end else begin
				held = 0;
			end
			envelopes_dropped++;
		end
	endtask

	// Build an envelope from the current registers, optionally damage one
	// field, and queue its first cut bytes. The rest goes to tail_bytes.
	task automatic queue_envelope(input flaw_t flaw, input fill_t fill, input int cut);
		logic [7:0]  env[ENV_N];
		logic [15:0] crc;
		logic [7:0]  spoil;
		spoil = 8'($urandom_range(1, 255));
		env[0] = cfg_start;
		env[ENV_VER_POS] = cfg_env_ver;
		for (int i = 2; i < ENV_N; i++) begin
			case (fill)
				FILL_ZERO: env[i] = 8'h00;
				FILL_ONES: env[i] = 8'hFF;
				default:   env[i] = 8'($urandom_range(255));
			endcase
		end
		env[INNER_OFFSET]     = cfg_marker;
		env[INNER_OFFSET + 1] = cfg_fver;
		env[INNER_OFFSET + 2] = cfg_kind;
		crc = CRC_INIT;
		for (int i = 0; i < INNER_N - 2; i++) crc = crc_step(crc, env[INNER_OFFSET + i]);
		env[INNER_OFFSET + INNER_N - 2] = crc[15:8];
		env[INNER_OFFSET + INNER_N - 1] = crc[7:0];
		case (flaw)
			FLAW_ENV_VER: env[ENV_VER_POS] ^= spoil;
			FLAW_MARKER:  env[INNER_OFFSET] ^= spoil;
			FLAW_FVER:    env[INNER_OFFSET + 1] ^= spoil;
			FLAW_KIND:    env[INNER_OFFSET + 2] ^= spoil;
			FLAW_CRC_HI:  env[INNER_OFFSET + INNER_N - 2] ^= spoil;
			FLAW_CRC_LO:  env[INNER_OFFSET + INNER_N - 1] ^= spoil;
			default: ;
		endcase
		tail_bytes.delete();
		for (int i = 0; i < ENV_N; i++) begin
			if (i < cut) host_bytes_todo.push_back(env[i]);
			else tail_bytes.push_back(env[i]);
		end
	endtask

	// Bytes that never match the start byte, so an empty buffer drops them.
	task automatic queue_noise(input int n);
		logic [7:0] nb;
		repeat (n) begin
			do nb = 8'($urandom_range(255)); while (nb == cfg_start);
			host_bytes_todo.push_back(nb);
		end
	endtask

	// A register write is presented at one edge and taken at the next.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		case (idx)
			CFG_START_BYTE:   cfg_start   = val;
			CFG_ENV_VERSION:  cfg_env_ver = val;
			CFG_FRAME_MARKER: cfg_marker  = val;
			CFG_FRAME_VER:    cfg_fver    = val;
			CFG_FRAME_KIND:   cfg_kind    = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input logic [7:0] sb, input logic [7:0] ev, input logic [7:0] mk,
		input logic [7:0] fv, input logic [7:0] kd);
		write_reg(CFG_START_BYTE, sb);
		write_reg(CFG_ENV_VERSION, ev);
		write_reg(CFG_FRAME_MARKER, mk);
		write_reg(CFG_FRAME_VER, fv);
		write_reg(CFG_FRAME_KIND, kd);
	endtask

	// Let every queued byte go in and every owed beat come out, then give the
	// block time to finish a check, scan and copy that produce no beat.
	task automatic wait_drained();
		while (host_bytes_todo.size() != 0 || rx_valid || frame_beats_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Host side driver. A beat on offer stays put until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else if (!rx_valid || !rx_stall) begin
			if (host_bytes_todo.size() != 0 &&
				(calm || $urandom_range(99) >= IDLE_PERCENT)) begin
				rx_valid <= 1'b1;
				rx_byte  <= host_bytes_todo.pop_front();
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// Radio side receiver. Once armed, it holds off for a long stretch as soon
	// as a frame starts to come out, so the block backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall    <= 1'b0;
			holdoff_left <= 0;
			holdoff_done <= 1'b0;
		end else if (holdoff_left != 0) begin
			out_stall    <= 1'b1;
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_armed && !holdoff_done && out_valid) begin
			out_stall    <= 1'b1;
			holdoff_left <= HOLDOFF_CYCLES;
			holdoff_done <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Model update on each byte taken, then the check of each beat delivered.
	always @(posedge clk) begin
		radio_beat_t due;
		if (arst_n) begin
			if (rx_valid && !rx_stall) begin
				rx_bytes_taken++;
				take_host_byte(rx_byte);
			end
			if (out_valid && !out_stall) begin
				radio_beats_checked++;
				if (frame_beats_due.size() == 0) begin
					$display("%0t: unexpected radio beat, expected none, got byte %02h last %0b",
						$time, out_byte, out_last);
					mismatches++;
				end else begin
					due = frame_beats_due.pop_front();
					if (out_byte !== due.data) begin
						$display("%0t: out_byte mismatch, expected %02h, got %02h",
							$time, due.data, out_byte);
						mismatches++;
					end
					if (out_last !== due.last) begin
						$display("%0t: out_last mismatch, expected %0b, got %0b",
							$time, due.last, out_last);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog: the run is stuck if no beat moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (rx_valid && !rx_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no beat moved for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int budget;
		int pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part with the register values out of reset. A cut-short
		// envelope followed by a whole one: the check fails, the resync keeps
		// the bytes from the next start byte, and the whole envelope passes
		// once the buffer fills again. The receiver holds off for a long
		// stretch on the first beat while the host side keeps offering noise,
		// which the empty buffer must drop afterwards.
		holdoff_armed = 1'b1;
		queue_envelope(FLAW_NONE, FILL_RANDOM, 12);
		queue_envelope(FLAW_NONE, FILL_ONES, ENV_N);
		host_bytes_todo.push_back(8'h00);
		host_bytes_todo.push_back(8'hFF);
		queue_noise(3);
		wait_drained();

		// Registers at their lowest values. Writes to indexes past the last
		// register follow; if any of them landed, the envelope would fail.
		write_all(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		for (int i = CFG_IDX_SPARE_LO; i <= CFG_IDX_SPARE_HI; i++)
			write_reg(i[CFG_IDX_W-1:0], 8'($urandom_range(255)));
		queue_envelope(FLAW_NONE, FILL_ZERO, ENV_N);
		wait_drained();

		// Registers at their highest values.
		write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_envelope(FLAW_NONE, FILL_ONES, ENV_N);
		wait_drained();

		// A register changed halfway through collection: the check uses the
		// new value, so this envelope is turned away.
		queue_envelope(FLAW_NONE, FILL_RANDOM, ENV_N / 2);
		wait_drained();
		write_reg(CFG_FRAME_KIND, cfg_kind ^ 8'h5A);
		while (tail_bytes.size() != 0) host_bytes_todo.push_back(tail_bytes.pop_front());
		wait_drained();

		// Random part. Mostly well-formed envelopes with random content, the
		// rest damaged, cut short, or noise. Each phase has its own registers,
		// and the last one runs with no idling on either side.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_all(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'($urandom_range(255)));
			calm = (phase == RANDOM_PHASES - 1);
			budget = host_bytes_todo.size();
			while (budget < PHASE_MIN_BYTES) begin
				pick = $urandom_range(99);
				if (pick < 60) begin
					queue_envelope(FLAW_NONE, FILL_RANDOM, ENV_N);
					budget += ENV_N;
				end else if (pick < 80) begin
					queue_envelope(flaw_t'($urandom_range(FLAW_ENV_VER, FLAW_CRC_LO)),
						FILL_RANDOM, ENV_N);
					budget += ENV_N;
				end else if (pick < 90) begin
					pick = $urandom_range(1, ENV_N - 1);
					queue_envelope(FLAW_NONE, FILL_RANDOM, pick);
					budget += pick;
				end else begin
					queue_noise($urandom_range(1, 6));
				end
			end
			wait_drained();
		end
		calm = 1'b0;

		wait_drained();
		$display("Took %0d host bytes and checked %0d radio beats.",
			rx_bytes_taken, radio_beats_checked);
		$display("Envelopes passed: %0d, turned away: %0d, receiver hold-off done: %0b.",
			envelopes_passed, envelopes_dropped, holdoff_done);
		if (mismatches == 0 && frame_beats_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- host_envelope_deframer_crc16_core.f -----
design/hedc_pkg.sv
design/hedc_ram.sv
design/hedc_check.sv
design/host_envelope_deframer_crc16_core.sv
tb/testbench.sv
